@@ rtl/bac_pkg.sv @@
package bac_pkg;

   localparam int unsigned PressW   = 19;
   localparam int unsigned TempW    = 14;
   localparam int unsigned ScaleW   = 23;
   localparam int unsigned LogW     = 21;
   localparam int unsigned MagW     = 20;
   localparam int unsigned AltW     = 27;
   localparam int unsigned QBits    = 15;

   localparam logic [31:0] RgTimes10Q15 = 32'd9591506;
   localparam logic [31:0] InvLog2eQ31  = 32'h58b90bfc;
   localparam logic [TempW-1:0] KelvinAdjust = TempW'(2731 - 400);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCALE = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_NORM  = 8'b0000_1000,
      ST_SQR   = 8'b0001_0000,
      ST_LN    = 8'b0010_0000,
      ST_ALT   = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/barometric_altitude_fixed_point_core.sv @@
// Each accepted word passes through the scale, divide, normalize, squaring, log and altitude steps
// before its result word; a zero quotient or a zero pressure ends early with a zero altitude.
// The block takes no new word until its result sits in the output register, so a result-side
// stall also holds back new words. The divide step, the normalize shifts and 15 squarings
// make up most of the work for each word.
// Reset (synchronous, active high) clears the sequencer, the output valid and the reference.
module barometric_altitude_fixed_point_core
   import bac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_packed_reading,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [AltW-1:0] rsp_altitude_cm,
   output logic                   rsp_reference_held
);

   state_type state_ff, state_in;

   // Ground reference; zero pressure means nothing latched yet.
   logic [PressW-1:0] gp_ff, gp_in;
   logic [TempW-1:0]  gt_ff, gt_in;

   // Per-word working registers.
   logic [PressW-1:0] p_ff, p_in;
   logic [TempW-1:0]  t_ff, t_in;
   logic              held_ff, held_in;
   logic [ScaleW-1:0] scale_ff, scale_in;
   logic [31:0]       x_ff, x_in;
   logic signed [LogW-1:0] y_ff, y_in;
   logic [QBits-1:0]  frac_ff, frac_in;
   logic              neg_ff, neg_in;
   logic [MagW-1:0]   mag_ff, mag_in;
   logic [AltW-1:0]   alt_ff, alt_in;
   logic              wait_ff, wait_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [AltW-1:0]   rsp_alt_ff, rsp_alt_in;
   logic              rsp_held_ff, rsp_held_in;

   // Shared multiplier and serial divider.
   logic [31:0]    mul_a, mul_b;
   logic           mul_signed;
   logic [63:0]    mul_prod;
   logic           div_start;
   div_status_type div_stat;
   logic [31:0]    div_quot;

   logic [PressW-1:0] word_p;
   logic [TempW-1:0]  word_t;
   logic [TempW:0]    temp_sum;
   logic [31:0]       ratio;
   logic [QBits+1:0]  sq;
   logic signed [LogW-1:0] ln_val;
   logic [LogW-1:0]   ln_abs;
   logic [AltW-1:0]   alt_mag;
   logic              out_free;

   bac_mul u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .op_signed  (mul_signed),
      .product_ff (mul_prod)
   );

   // The dividend is the ground pressure shifted up by 14 and cut to 32 bits.
   bac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({gp_ff[PressW-2:0], 14'b0}),
      .divisor  (p_ff),
      .status   (div_stat),
      .quotient (div_quot)
   );

   assign word_p   = req_packed_reading[PressW-1:0];
   assign word_t   = {1'b0, req_packed_reading[31:PressW]} + KelvinAdjust;
   assign temp_sum = {1'b0, gt_ff} + {1'b0, t_ff};
   assign ratio    = {div_quot[30:0], 1'b0};
   assign sq       = mul_prod[QBits+16:QBits];
   assign ln_val   = mul_prod[LogW+30:31];
   assign ln_abs   = ln_val[LogW-1] ? (~ln_val + LogW'(1)) : ln_val;
   assign alt_mag  = mul_prod[AltW+14:QBits];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign div_start = (state_ff == ST_SCALE) && wait_ff;

   // Multiplier operand selection for the step that issues this cycle.
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      mul_signed = 1'b0;
      unique case (state_ff)
         ST_SCALE: begin
            mul_a = RgTimes10Q15;
            mul_b = 32'(temp_sum[TempW:1]);
         end
         ST_SQR: begin
            mul_a = 32'(x_ff[15:0]);
            mul_b = 32'(x_ff[15:0]);
         end
         ST_LN: begin
            mul_a      = 32'(y_ff);
            mul_b      = InvLog2eQ31;
            mul_signed = 1'b1;
         end
         ST_ALT: begin
            mul_a = 32'(scale_ff);
            mul_b = 32'(mag_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      gp_in        = gp_ff;
      gt_in        = gt_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      held_in      = held_ff;
      scale_in     = scale_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      frac_in      = frac_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      alt_in       = alt_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_alt_in   = rsp_alt_ff;
      rsp_held_in  = rsp_held_ff;

      unique case (state_ff)
         ST_IDLE: begin
            wait_in = 1'b0;
            if (req_valid) begin
               p_in = word_p;
               t_in = word_t;
               if (word_p == '0) begin
                  // No pressure: zero altitude, reference untouched.
                  held_in  = (gp_ff != '0);
                  alt_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  held_in  = 1'b1;
                  if (gp_ff == '0) begin
                     gp_in = word_p;
                     gt_in = word_t;
                  end
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            // Issue cycle, then the product is taken; the divider starts alongside.
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else begin
               wait_in  = 1'b0;
               scale_in = mul_prod[ScaleW+QBits-1:QBits];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (ratio == '0) begin
                  alt_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  x_in     = ratio;
                  y_in     = '0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            // One shift a cycle until the value lies in [1, 2) in Q15.
            if (x_ff < 32'h0000_8000) begin
               x_in = {x_ff[30:0], 1'b0};
               y_in = y_ff - LogW'(32768);
            end else if (x_ff >= 32'h0001_0000) begin
               x_in = {1'b0, x_ff[31:1]};
               y_in = y_ff + LogW'(32768);
            end else begin
               frac_in  = QBits'(1) << (QBits - 1);
               wait_in  = 1'b0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            // Each squaring yields one fraction bit of the log.
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else begin
               wait_in = 1'b0;
               if (sq[16]) begin
                  x_in = 32'(sq[16:1]);
                  y_in = y_ff + LogW'(frac_ff);
               end else begin
                  x_in = 32'(sq[15:0]);
               end
               frac_in = frac_ff >> 1;
               if (frac_ff == QBits'(1)) begin
                  state_in = ST_LN;
               end
            end
         end
         ST_LN: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else begin
               wait_in  = 1'b0;
               neg_in   = ln_val[LogW-1];
               mag_in   = ln_abs[MagW-1:0];
               state_in = ST_ALT;
            end
         end
         ST_ALT: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else begin
               wait_in  = 1'b0;
               alt_in   = neg_ff ? (~alt_mag + AltW'(1)) : alt_mag;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // The result moves into the output register only once that register is empty or being read.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in   = alt_ff;
               rsp_held_in  = held_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      t_ff        <= t_in;
      held_ff     <= held_in;
      scale_ff    <= scale_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      frac_ff     <= frac_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      alt_ff      <= alt_in;
      rsp_alt_ff  <= rsp_alt_in;
      rsp_held_ff <= rsp_held_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         gp_ff        <= '0;
         gt_ff        <= '0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gp_ff        <= gp_in;
         gt_ff        <= gt_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_altitude_cm    = $signed(rsp_alt_ff);
   assign rsp_reference_held = rsp_held_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready right after taking a word");

   a_alt_needs_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_altitude_cm != '0) |-> rsp_reference_held)
      else $error("nonzero altitude without a ground reference");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");
`endif

endmodule

@@ rtl/bac_mul.sv @@
module bac_mul
   import bac_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic        op_signed,
   output logic [63:0] product_ff
);

   logic signed [32:0] a_ext;
   logic signed [32:0] b_ext;
   logic signed [65:0] full;
   logic [63:0]        product_in;

   // Operands are widened by one bit so one multiplier serves both signed and unsigned use.
   assign a_ext      = $signed({op_signed & op_a[31], op_a});
   assign b_ext      = $signed({op_signed & op_b[31], op_b});
   assign full       = a_ext * b_ext;
   assign product_in = full[63:0];

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ rtl/bac_div.sv @@
module bac_div
   import bac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       dividend,
   input  logic [PressW-1:0] divisor,
   output div_status_type    status,
   output logic [31:0]       quotient
);

   logic [31:0]       dvd_ff, dvd_in;
   logic [PressW-1:0] rem_ff, rem_in;
   logic [PressW-1:0] dsr_ff, dsr_in;
   logic [4:0]        count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PressW:0]   shifted;
   logic [PressW+1:0] diff;

   // Restoring division, one quotient bit per cycle; quotient bits shift into the dividend.
   assign shifted = {rem_ff, dvd_ff[31]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         dvd_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (diff[PressW+1]) begin
            rem_in = shifted[PressW-1:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
         end else begin
            rem_in = diff[PressW-1:0];
            dvd_in = {dvd_ff[30:0], 1'b1};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff;

endmodule
